FILE: sv/lfopaw_pkg.sv
// ----------------------------------------------------------------------------
// lfopaw_pkg
// Shared types and constants for the LFO phase accumulator / waveshaper.
// ----------------------------------------------------------------------------
package lfopaw_pkg;

  localparam int unsigned PhaseBitsDef     = 24;
  localparam int unsigned SineTableBitsDef = 8;

  localparam int unsigned StepW   = 24;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 2;

  // pi/2 in Q30
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE      = 2'd0,
    WAVE_SAW_UP    = 2'd1,
    WAVE_SAW_DOWN  = 2'd2,
    WAVE_SQUARE    = 2'd3
  } wave_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_WAVE_SELECT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_in;
    logic                      add_input;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic signed [SampleW-1:0] wave_out;
  } out_t;

  typedef struct packed {
    logic              step_we;
    logic [StepW-1:0]  step_wdata;
    logic              advance;
  } phase_ctrl_t;

endpackage

FILE: sv/lfopaw_phase.sv
// ----------------------------------------------------------------------------
// lfopaw_phase
// Phase step register and phase accumulator; presents the top 16 phase bits.
// ----------------------------------------------------------------------------
module lfopaw_phase #(
  parameter int unsigned PHASE_BITS = lfopaw_pkg::PhaseBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfopaw_pkg::phase_ctrl_t  ctrl_i,
  output logic [15:0]              phase_u_o
);

  logic [PHASE_BITS-1:0] step_q, step_d;
  logic [PHASE_BITS-1:0] acc_q, acc_d;

  // fit the 24-bit step word to the accumulator width
  if (PHASE_BITS <= lfopaw_pkg::StepW) begin : g_step_trunc
    assign step_d = ctrl_i.step_wdata[PHASE_BITS-1:0];
  end else begin : g_step_ext
    assign step_d = {{(PHASE_BITS - lfopaw_pkg::StepW){1'b0}}, ctrl_i.step_wdata};
  end

  assign acc_d = acc_q + step_q;  // wraps modulo 2^PHASE_BITS

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctrl_i.step_we) begin
        step_q <= step_d;
      end
      if (ctrl_i.advance) begin
        acc_q <= acc_d;
      end
    end
  end

  if (PHASE_BITS >= 16) begin : g_u_top
    assign phase_u_o = acc_q[PHASE_BITS-1 -: 16];
  end else begin : g_u_shift
    assign phase_u_o = {acc_q, {(16 - PHASE_BITS){1'b0}}};
  end

endmodule

FILE: sv/lfopaw_shaper.sv
// ----------------------------------------------------------------------------
// lfopaw_shaper
// Maps the 16-bit phase to the selected waveform and adds the input sample.
// ----------------------------------------------------------------------------
module lfopaw_shaper #(
  parameter int unsigned SINE_TABLE_BITS = lfopaw_pkg::SineTableBitsDef
) (
  input  lfopaw_pkg::wave_e  wave_sel_i,
  input  logic [15:0]        phase_u_i,
  input  lfopaw_pkg::in_t    in_data_i,
  output lfopaw_pkg::out_t   out_data_o
);

  localparam int unsigned SinN = 1 << SINE_TABLE_BITS;

  typedef logic [14:0] sin_tab_t [SinN+1];

  // quarter-wave table, Q30 Taylor series rounded to Q1.15
  function automatic sin_tab_t build_tab();
    sin_tab_t           t;
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    for (int k = 0; k <= SinN; k++) begin
      a    = (64'(k) * lfopaw_pkg::HalfPiQ30) >> SINE_TABLE_BITS;
      a2   = (a * a) >> 30;
      term = a;
      acc  = signed'(a);
      term = ((term * a2) >> 30) / 64'd6;   acc = acc - signed'(term);
      term = ((term * a2) >> 30) / 64'd20;  acc = acc + signed'(term);
      term = ((term * a2) >> 30) / 64'd42;  acc = acc - signed'(term);
      term = ((term * a2) >> 30) / 64'd72;  acc = acc + signed'(term);
      term = ((term * a2) >> 30) / 64'd110; acc = acc - signed'(term);
      term = ((term * a2) >> 30) / 64'd156; acc = acc + signed'(term);
      term = ((term * a2) >> 30) / 64'd210; acc = acc - signed'(term);
      term = ((term * a2) >> 30) / 64'd272; acc = acc + signed'(term);
      if (acc < 0) begin
        acc = '0;
      end
      acc = (acc + 64'sd16384) >>> 15;
      if (acc > 64'sd32767) begin
        acc = 64'sd32767;
      end
      t[k] = acc[14:0];
    end
    return t;
  endfunction

  localparam sin_tab_t SinTab = build_tab();

  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS-1:0]   tab_i;
  logic [SINE_TABLE_BITS:0]     tab_j;
  logic signed [15:0]           sin_mag;
  logic signed [15:0]           saw_up;
  logic signed [15:0]           wave;
  logic signed [16:0]           sum;
  logic signed [15:0]           sum_sat;

  assign quad  = phase_u_i[15:14];
  assign tab_i = phase_u_i[13 -: SINE_TABLE_BITS];
  // odd quadrants read the table mirrored
  assign tab_j = quad[0] ? ((SINE_TABLE_BITS+1)'(SinN) - {1'b0, tab_i}) : {1'b0, tab_i};
  assign sin_mag = signed'({1'b0, SinTab[tab_j]});
  assign saw_up  = signed'({~phase_u_i[15], phase_u_i[14:0]});

  always_comb begin
    case (wave_sel_i)
      lfopaw_pkg::WAVE_SINE:     wave = quad[1] ? sin_mag : -sin_mag;
      lfopaw_pkg::WAVE_SAW_UP:   wave = saw_up;
      lfopaw_pkg::WAVE_SAW_DOWN: wave = (phase_u_i == 16'd0) ? 16'sh7FFF : -saw_up;
      lfopaw_pkg::WAVE_SQUARE:   wave = phase_u_i[15] ? 16'sh7FFF : 16'sh8000;
      default:                   wave = saw_up;
    endcase
  end

  assign sum = 17'(in_data_i.sample_in) + 17'(wave);

  always_comb begin
    if (sum > 17'sd32767) begin
      sum_sat = 16'sh7FFF;
    end else if (sum < -17'sd32768) begin
      sum_sat = 16'sh8000;
    end else begin
      sum_sat = sum[15:0];
    end
  end

  assign out_data_o.wave_out   = wave;
  assign out_data_o.sample_out = in_data_i.add_input ? sum_sat : wave;

endmodule

FILE: sv/lfo_phase_accumulator_waveshaper_core.sv
// ----------------------------------------------------------------------------
// lfo_phase_accumulator_waveshaper_core
// LFO: phase accumulator, sine/saw/square shaper, saturating add to input.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  in      | sink      | in_valid_i / in_ready_o   | in_data_i  (in_t)
//  out     | source    | out_valid_o / out_ready_i | out_data_o (out_t)
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One word per cycle while in_ready_o is high; the result is captured in the
//  output register on accept. The phase advances on each accepted word.
//  in_ready_o drops only while a result sits unclaimed and out_ready_i is low.
//  Reset clears phase, step, wave select and the output valid. cfg always ready.
// ----------------------------------------------------------------------------
module lfo_phase_accumulator_waveshaper_core #(
  parameter int unsigned PHASE_BITS      = lfopaw_pkg::PhaseBitsDef,
  parameter int unsigned SINE_TABLE_BITS = lfopaw_pkg::SineTableBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lfopaw_pkg::in_t                   in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lfopaw_pkg::out_t                  out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lfopaw_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lfopaw_pkg::StepW-1:0]      cfg_data_i
);

  lfopaw_pkg::phase_ctrl_t phase_ctrl;
  lfopaw_pkg::wave_e       wave_sel_q, wave_sel_d;
  lfopaw_pkg::out_t        result;
  lfopaw_pkg::out_t        out_data_q;
  logic                    out_valid_q, out_valid_d;
  logic [15:0]             phase_u;
  logic                    in_fire;
  logic                    sel_we;
  logic                    step_we;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    step_we = 1'b0;
    sel_we  = 1'b0;
    unique case (cfg_index_i)
      lfopaw_pkg::CFG_PHASE_STEP:  step_we = cfg_valid_i;
      lfopaw_pkg::CFG_WAVE_SELECT: sel_we  = cfg_valid_i;
      default: ;
    endcase
  end

  assign wave_sel_d = lfopaw_pkg::wave_e'(cfg_data_i[1:0]);

  assign phase_ctrl.step_we    = step_we;
  assign phase_ctrl.step_wdata = cfg_data_i;
  assign phase_ctrl.advance    = in_fire;

  lfopaw_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (phase_ctrl),
    .phase_u_o (phase_u)
  );

  lfopaw_shaper #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_shaper (
    .wave_sel_i (wave_sel_q),
    .phase_u_i  (phase_u),
    .in_data_i  (in_data_i),
    .out_data_o (result)
  );

  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wave_sel_q  <= lfopaw_pkg::WAVE_SINE;
    end else begin
      out_valid_q <= out_valid_d;
      if (sel_we) begin
        wave_sel_q <= wave_sel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/lfopaw_checker.sv
// ----------------------------------------------------------------------------
// lfopaw_checker
// Port-level checks for the LFO core, bound to the top level.
// ----------------------------------------------------------------------------
module lfopaw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input lfopaw_pkg::in_t                in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input lfopaw_pkg::out_t               out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out valid dropped before accept");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out word changed while stalled");

  // accepted word always shows up next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // no backpressure on input unless a result is pending
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // without the add, the sample equals the wave
  a_pass_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.add_input
      |=> out_data_o.sample_out == out_data_o.wave_out)
    else $error("sample_out differs from wave_out without add");

endmodule

bind lfo_phase_accumulator_waveshaper_core lfopaw_checker u_lfopaw_checker (.*);

FILE: bench/lfo_phase_accumulator_waveshaper_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfo_phase_accumulator_waveshaper_core_tb
// Self-checking bench for the LFO core. A local model of the phase
// accumulator, quarter-wave sine table and saw/square shapers predicts each
// output word; a monitor compares every accepted output against the oldest
// prediction. Directed corners come first, then input back-pressure, then
// randomized phases with changing step and waveform.
// ----------------------------------------------------------------------------
module lfo_phase_accumulator_waveshaper_core_tb;

  typedef longint unsigned u64_t;
  typedef logic [lfopaw_pkg::StepW-1:0] step_t;

  localparam int unsigned SineN      = 1 << lfopaw_pkg::SineTableBitsDef;
  localparam step_t StepMax     = {lfopaw_pkg::StepW{1'b1}};
  localparam step_t StepQuarter = 24'h400000;
  localparam logic [lfopaw_pkg::CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [lfopaw_pkg::CfgIdxW-1:0] CfgIdxSpareB = 2'd3;
  localparam int SatHi = 32767;
  localparam int SatLo = -32768;
  localparam int unsigned HoldCycles   = 250;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned WordsPerPhase = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  lfopaw_pkg::in_t  in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  lfopaw_pkg::out_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [lfopaw_pkg::CfgIdxW-1:0] cfg_index = '0;
  step_t                          cfg_data = '0;

  // model state
  logic [lfopaw_pkg::PhaseBitsDef-1:0] model_phase;
  step_t                               model_step;
  lfopaw_pkg::wave_e                   model_wave;
  int                                  sine_tbl [0:SineN];

  lfopaw_pkg::out_t expected_words [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  bit          idle_on;
  bit          hold_req;
  int unsigned hold_left;

  lfo_phase_accumulator_waveshaper_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Q30 Taylor series for sin over the first quadrant, rounded to Q15
  function automatic void build_sine_table();
    u64_t ang, ang2, term;
    longint sum;
    for (int k = 0; k <= SineN; k++) begin
      ang  = (u64_t'(k) * u64_t'(lfopaw_pkg::HalfPiQ30)) / u64_t'(SineN);
      ang2 = (ang * ang) >> 30;
      term = ang;
      sum  = longint'(ang);
      for (int n = 1; n < 16; n += 2) begin
        term = ((term * ang2) >> 30) / u64_t'((n + 1) * (n + 2));
        if (((n + 1) / 2) % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) / 32768;
      if (sum > SatHi) sum = longint'(SatHi);
      sine_tbl[k] = int'(sum);
    end
  endfunction

  function automatic int sat16(int v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  // wave at the current phase, optionally mixed into the input sample
  function automatic lfopaw_pkg::out_t shape_and_mix(lfopaw_pkg::in_t word);
    logic [15:0]      u;
    logic [1:0]       quad;
    int               idx, s, w, mix;
    lfopaw_pkg::out_t res;
    u = model_phase[lfopaw_pkg::PhaseBitsDef-1 -: 16];
    case (model_wave)
      lfopaw_pkg::WAVE_SINE: begin
        quad = u[15:14];
        idx  = int'(u[13 -: lfopaw_pkg::SineTableBitsDef]);
        s = quad[0] ? sine_tbl[SineN - idx] : sine_tbl[idx];
        if (quad[1]) s = -s;
        w = -s;
      end
      lfopaw_pkg::WAVE_SAW_UP:   w = int'(u) - 32768;
      lfopaw_pkg::WAVE_SAW_DOWN: w = sat16(32768 - int'(u));
      default:                   w = (u < 16'h8000) ? SatLo : SatHi;
    endcase
    mix = word.add_input ? sat16(int'(word.sample_in) + w) : w;
    res.sample_out = mix[15:0];
    res.wave_out   = w[15:0];
    return res;
  endfunction

  // offer one word, predict its result once accepted
  task automatic send_word(logic signed [15:0] sample, logic add);
    while (idle_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample_in: sample, add_input: add};
    do @(posedge clk_i); while (!in_ready_o);
    expected_words.push_back(shape_and_mix('{sample_in: sample, add_input: add}));
    model_phase = model_phase + model_step;
  endtask

  task automatic send_random_word();
    logic signed [15:0] s;
    case ($urandom_range(7))
      0: s = 16'sh7fff;
      1: s = 16'sh8000;
      default: s = 16'($urandom);
    endcase
    send_word(s, 1'($urandom_range(1)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // only called while idle
  task automatic cfg_write(logic [lfopaw_pkg::CfgIdxW-1:0] idx, step_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      lfopaw_pkg::CFG_PHASE_STEP:  model_step = data;
      lfopaw_pkg::CFG_WAVE_SELECT: model_wave = lfopaw_pkg::wave_e'(data[1:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // output monitor and receiver
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lfopaw_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", int'(out_data_o.wave_out), 0);
      end else begin
        want = expected_words.pop_front();
        if (out_data_o.sample_out !== want.sample_out)
          report_mismatch("sample_out", int'(out_data_o.sample_out), int'(want.sample_out));
        if (out_data_o.wave_out !== want.wave_out)
          report_mismatch("wave_out", int'(out_data_o.wave_out), int'(want.wave_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // reset state: sine, step 0, phase held at zero
  task automatic test_reset_state();
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b1);
    wait_idle();
  endtask

  // quarter-cycle step hits each quadrant edge: saw extremes, falling saw
  // saturation at u = 0, square sign change, sine peaks; extreme samples
  // drive the saturating add both ways
  task automatic test_waveform_corners();
    lfopaw_pkg::wave_e wv;
    cfg_write(lfopaw_pkg::CFG_PHASE_STEP, StepQuarter);
    wv = wv.first();
    do begin
      cfg_write(lfopaw_pkg::CFG_WAVE_SELECT, step_t'(wv));
      send_word(16'sh7fff, 1'b1);
      send_word(16'sh8000, 1'b1);
      send_word(16'($urandom), 1'b0);
      send_word(16'sh7fff, 1'b1);
      wait_idle();
      wv = wv.next();
    end while (wv != wv.first());
    // largest step wraps the accumulator
    cfg_write(lfopaw_pkg::CFG_PHASE_STEP, StepMax);
    send_word(16'sh0000, 1'b1);
    send_word(16'sh8000, 1'b1);
    wait_idle();
  endtask

  // writes to indexes past the register list must not change anything
  task automatic test_spare_index();
    cfg_write(CfgIdxSpareA, step_t'($urandom));
    cfg_write(CfgIdxSpareB, step_t'($urandom));
    send_word(16'sh1234, 1'b1);
    send_word(16'sh7fff, 1'b1);
    wait_idle();
  endtask

  // receiver stalls long enough for the core to back up its input
  task automatic test_output_stall();
    idle_on = 1'b0;
    cfg_write(lfopaw_pkg::CFG_WAVE_SELECT, step_t'(lfopaw_pkg::WAVE_SINE));
    cfg_write(lfopaw_pkg::CFG_PHASE_STEP, step_t'($urandom));
    hold_req = 1'b1;
    repeat (40) send_random_word();
    wait_idle();
  endtask

  task automatic test_random_phases();
    step_t step;
    for (int ph = 0; ph < 10; ph++) begin
      idle_on = (ph < 7);
      if (ph == 0) step = StepMax;
      else if (ph == 1) step = '0;
      else begin
        case ($urandom_range(3))
          0: step = step_t'($urandom_range(4096));
          1: step = StepMax - step_t'($urandom_range(4096));
          default: step = step_t'($urandom);
        endcase
      end
      cfg_write(lfopaw_pkg::CFG_PHASE_STEP, step);
      cfg_write(lfopaw_pkg::CFG_WAVE_SELECT, step_t'($urandom));
      if ($urandom_range(3) == 0)
        cfg_write($urandom_range(1) ? CfgIdxSpareA : CfgIdxSpareB, step_t'($urandom));
      repeat (WordsPerPhase) send_random_word();
      wait_idle();
    end
  endtask

  initial begin
    build_sine_table();
    model_phase = '0;
    model_step  = '0;
    model_wave  = lfopaw_pkg::WAVE_SINE;
    err_cnt     = 0;
    cycle_cnt   = 0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    hold_left   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_waveform_corners();
    test_spare_index();
    test_output_stall();
    test_random_phases();

    wait_idle();
    if (err_cnt == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
